// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition in one cycle that requires a property in the next cycle.
`define CPR_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ----- sv/cpr_pkg.sv -----
`default_nettype none

package cpr_pkg;

	// Coordinate widths.
	localparam int POS_BITS = 20;
	localparam int LEN_BITS = POS_BITS + 1;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0] REF_CAP = LEN_BITS'(1) << POS_BITS;

	// Default operation queue depth.
	localparam int DEF_MAX_OPS = 32;

	// Input item kinds.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_CIGAR = 2'd1;
	localparam logic [1:0] KIND_BASE  = 2'd2;

	// Result kinds.
	localparam logic [1:0] RES_WRITE   = 2'd0;
	localparam logic [1:0] RES_GAP     = 2'd1;
	localparam logic [1:0] RES_INVALID = 2'd2;

	// Base codes.
	localparam logic [2:0] BASE_A   = 3'd0;
	localparam logic [2:0] BASE_C   = 3'd1;
	localparam logic [2:0] BASE_G   = 3'd2;
	localparam logic [2:0] BASE_T   = 3'd3;
	localparam logic [2:0] BASE_N   = 3'd4;
	localparam logic [2:0] BASE_GAP = 3'd5;

	// Characters.
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_ZERO   = 8'd48;
	localparam logic [7:0] CH_NINE   = 8'd57;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_DIFF = 8'd32;
	localparam int         DEC_RADIX = 10;

	// Channel payloads.
	typedef struct packed {
		logic [1:0]          kind;
		logic [POS_BITS-1:0] start_position;
		logic [7:0]          symbol;
	} item_t;

	typedef struct packed {
		logic [1:0]          result_kind;
		logic [POS_BITS-1:0] ref_position;
		logic [2:0]          base_code;
		logic [LEN_BITS-1:0] run_length;
	} result_t;

	// One queued M, I or S operation.
	typedef struct packed {
		logic [LEN_BITS-1:0] len;
		logic                is_match;
		logic [LEN_BITS-1:0] ref_start;
	} op_entry_t;

	// Requests from the control logic to the operation queue.
	typedef struct packed {
		logic      clear;
		logic      push;
		logic      pop;
		op_entry_t push_entry;
	} queue_cmd_t;

	// Queue status seen by the control logic.
	typedef struct packed {
		logic                empty;
		logic                full;
		op_entry_t           head;
		logic [LEN_BITS-1:0] consumed;
	} queue_stat_t;

	// Maps a query base character to its code; lowercase is folded first.
	function automatic logic [2:0] base_code_of(input logic [7:0] c);
		logic [7:0] u;
		logic [2:0] code;
		u = (c inside {[CH_LOW_A:CH_LOW_Z]}) ? c - CASE_DIFF : c;
		case (u)
			CH_A:    code = BASE_A;
			CH_C:    code = BASE_C;
			CH_G:    code = BASE_G;
			CH_T:    code = BASE_T;
			default: code = BASE_N;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- sv/cpr_if.sv -----
`default_nettype none

// Input item channel.
interface cpr_item_if import cpr_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface cpr_result_if import cpr_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/cpr_op_queue.sv -----
`default_nettype none

`include "assert_macros.svh"

module cpr_op_queue import cpr_pkg::*; #(
	parameter int MAX_OPS = DEF_MAX_OPS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire queue_cmd_t  cmd,
	output queue_stat_t      stat
);

	localparam int ADDR_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
	localparam int CNT_W  = $clog2(MAX_OPS + 1);

	op_entry_t           mem [MAX_OPS];
	logic [ADDR_W-1:0]   head_q;
	logic [ADDR_W-1:0]   tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [LEN_BITS-1:0] consumed_q;
	op_entry_t           head_ent_q;
	op_entry_t           next_ent_q;

	logic [ADDR_W-1:0]   head_d;
	logic [ADDR_W-1:0]   tail_d;
	logic [CNT_W-1:0]    count_d;
	logic [LEN_BITS-1:0] consumed_d;
	logic [LEN_BITS-1:0] consumed_inc;
	logic [ADDR_W-1:0]   rd_addr;
	logic                pop_last;

	function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
		return (a == ADDR_W'(MAX_OPS - 1)) ? '0 : a + ADDR_W'(1);
	endfunction

	// The head entry is finished when this base uses up its length.
	assign consumed_inc = consumed_q + LEN_BITS'(1);
	assign pop_last     = cmd.pop && (consumed_inc >= head_ent_q.len);

	// Pointer, count and consumed-position updates.
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		consumed_d = consumed_q;
		if (cmd.clear) begin
			head_d     = '0;
			tail_d     = '0;
			count_d    = '0;
			consumed_d = '0;
		end else if (cmd.push) begin
			tail_d  = slot_inc(tail_q);
			count_d = count_q + CNT_W'(1);
		end else if (pop_last) begin
			head_d     = slot_inc(head_q);
			count_d    = count_q - CNT_W'(1);
			consumed_d = '0;
		end else if (cmd.pop) begin
			consumed_d = consumed_inc;
		end
	end

	// The entry after the head is prefetched every cycle.
	assign rd_addr = slot_inc(head_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			consumed_q <= '0;
		end else begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			consumed_q <= consumed_d;
		end
	end

	// Queue storage: one write port at the tail, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= cmd.push_entry;
		end
		if (cmd.push && (tail_q == rd_addr)) begin
			next_ent_q <= cmd.push_entry;
		end else begin
			next_ent_q <= mem[rd_addr];
		end
	end

	// Head entry register: loaded by a push into an empty queue or by an advance.
	always_ff @(posedge clk) begin
		if (cmd.push && (count_q == '0)) begin
			head_ent_q <= cmd.push_entry;
		end else if (pop_last) begin
			head_ent_q <= next_ent_q;
		end
	end

	assign stat.empty    = (count_q == '0);
	assign stat.full     = (count_q == CNT_W'(MAX_OPS));
	assign stat.head     = head_ent_q;
	assign stat.consumed = consumed_q;

	`CPR_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_OPS), "queue count exceeds depth")
	`CPR_ASSERT(a_push_not_full, !cmd.push || (count_q != CNT_W'(MAX_OPS)), "push into full queue")
	`CPR_ASSERT(a_pop_not_empty, !cmd.pop || (count_q != '0), "pop from empty queue")

endmodule

`default_nettype wire

// ----- sv/cigar_read_projector_core.sv -----
// Channel   Role    Payload                                        Transfer
// items     sink    kind, start_position, symbol                   valid & ready
// results   source  result_kind, ref_position, base_code, run_len  valid & ready
// cfg       write   ref_length (cfg_wr_data)                       cfg_wr_en
//
// One item per cycle unless a result waits untaken; its result, if any, shows the next cycle.
// The rate is set by the update of the queue head, which uses a
// prefetched copy of the next queue entry read from the one memory port.
// A waiting result holds in the output register; items keep flowing while it is taken.
// Reset clears pointers, counters and flags at once; the queue memory needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module cigar_read_projector_core import cpr_pkg::*; #(
	parameter int MAX_OPS = DEF_MAX_OPS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [LEN_BITS-1:0] cfg_wr_data,
	cpr_item_if.sink                 items,
	cpr_result_if.source             results
);

	localparam int ACC_W = LEN_BITS + 4;
	localparam int SUM_W = LEN_BITS + 1;

	logic [LEN_BITS-1:0] ref_length_q;
	logic [LEN_BITS-1:0] acc_q;
	logic [LEN_BITS-1:0] cursor_q;
	logic                record_invalid_q;
	logic                out_valid_q;
	result_t             out_data_q;

	logic [LEN_BITS-1:0] acc_d;
	logic [LEN_BITS-1:0] cursor_d;
	logic                invalid_d;
	logic                res_valid;
	result_t             res;
	queue_cmd_t          qcmd;
	queue_stat_t         qstat;
	item_t               it;
	logic                fire;
	logic [LEN_BITS-1:0] eff_len;
	logic [ACC_W-1:0]    acc_next;
	logic [LEN_BITS-1:0] acc_sat;
	logic [SUM_W-1:0]    cursor_sum;
	logic [LEN_BITS-1:0] cursor_sat;
	logic [LEN_BITS-1:0] room;
	logic [SUM_W-1:0]    base_pos;
	logic                start_zero;
	logic                gap_out;
	logic                out_stall;

	assign it           = items.data;
	assign items.ready  = !out_valid_q || results.ready;
	assign fire         = items.valid && items.ready;

	// Reference length limited to the coordinate range.
	assign eff_len = (ref_length_q > REF_CAP) ? REF_CAP : ref_length_q;

	// Decimal length accumulation with saturation.
	assign acc_next = ACC_W'(acc_q) * ACC_W'(DEC_RADIX) + ACC_W'(it.symbol - CH_ZERO);
	assign acc_sat  = (acc_next > ACC_W'(LEN_MAX)) ? LEN_MAX : acc_next[LEN_BITS-1:0];

	// Cursor advance by the pending length, saturating.
	assign cursor_sum = SUM_W'(cursor_q) + SUM_W'(acc_q);
	assign cursor_sat = (cursor_sum > SUM_W'(LEN_MAX)) ? LEN_MAX : cursor_sum[LEN_BITS-1:0];

	// Space left before the reference end, valid when the cursor is inside.
	assign room = eff_len - cursor_q;

	// Reference position of the base at the queue head.
	assign base_pos = SUM_W'(qstat.head.ref_start) + SUM_W'(qstat.consumed);

	// Item decode and state update.
	always_comb begin
		acc_d     = acc_q;
		cursor_d  = cursor_q;
		invalid_d = record_invalid_q;
		res_valid = 1'b0;
		res       = '0;
		qcmd      = '0;
		qcmd.push_entry.len       = acc_q;
		qcmd.push_entry.is_match  = (it.symbol == CH_M);
		qcmd.push_entry.ref_start = cursor_q;
		if (fire) begin
			case (it.kind)
				KIND_START: begin
					qcmd.clear = 1'b1;
					acc_d      = '0;
					invalid_d  = 1'b0;
					if (it.start_position == '0) begin
						cursor_d        = '0;
						invalid_d       = 1'b1;
						res_valid       = 1'b1;
						res.result_kind = RES_INVALID;
					end else begin
						cursor_d = {1'b0, it.start_position} - LEN_BITS'(1);
					end
				end
				KIND_CIGAR: begin
					if (!record_invalid_q) begin
						if (it.symbol inside {[CH_ZERO:CH_NINE]}) begin
							acc_d = acc_sat;
						end else begin
							acc_d = '0;
							case (it.symbol)
								CH_M, CH_I, CH_S: begin
									if ((acc_q != '0) && qstat.full) begin
										invalid_d       = 1'b1;
										res_valid       = 1'b1;
										res.result_kind = RES_INVALID;
									end else begin
										qcmd.push = (acc_q != '0);
										if (it.symbol == CH_M) begin
											cursor_d = cursor_sat;
										end
									end
								end
								CH_D: begin
									cursor_d = cursor_sat;
									if ((cursor_q < eff_len) && (acc_q != '0)) begin
										res_valid        = 1'b1;
										res.result_kind  = RES_GAP;
										res.ref_position = cursor_q[POS_BITS-1:0];
										res.base_code    = BASE_GAP;
										res.run_length   = (acc_q > room) ? room : acc_q;
									end
								end
								CH_H: begin
								end
								default: begin
									invalid_d       = 1'b1;
									res_valid       = 1'b1;
									res.result_kind = RES_INVALID;
								end
							endcase
						end
					end
				end
				KIND_BASE: begin
					if (!record_invalid_q && !qstat.empty) begin
						qcmd.pop = 1'b1;
						if (qstat.head.is_match && (base_pos < SUM_W'(eff_len))) begin
							res_valid        = 1'b1;
							res.result_kind  = RES_WRITE;
							res.ref_position = base_pos[POS_BITS-1:0];
							res.base_code    = base_code_of(it.symbol);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	cpr_op_queue #(
		.MAX_OPS (MAX_OPS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.stat   (qstat)
	);

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_length_q     <= REF_CAP;
			acc_q            <= '0;
			cursor_q         <= '0;
			record_invalid_q <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ref_length_q <= cfg_wr_data;
			end
			acc_q            <= acc_d;
			cursor_q         <= cursor_d;
			record_invalid_q <= invalid_d;
			if (items.ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_data_q;

	// Conditions watched by the checks below.
	assign start_zero = fire && (it.kind == KIND_START) && (it.start_position == '0);
	assign gap_out    = results.valid && (results.data.result_kind == RES_GAP);
	assign out_stall  = results.valid && !results.ready;

	`CPR_ASSERT_NEXT(a_start_zero_invalid, start_zero, record_invalid_q, "zero start left record valid")
	`CPR_ASSERT(a_gap_nonzero, !gap_out || (results.data.run_length != '0), "gap run of zero length")
	`CPR_ASSERT_NEXT(a_out_hold, out_stall, results.valid && $stable(results.data), "result changed")

endmodule

`default_nettype wire
